/* sv/sst_pkg.sv */
// ============================================================================
// sst_pkg: shared types and constants for the script source tokenizer
// Holds the lexer mode encoding, the token kind and error codes, the result
// word layout and the character class helpers.
// ============================================================================
package sst_pkg;

    // Result queue depth and the most results one source byte can cause.
    localparam int MAX_RES = 3;
    localparam int QDEPTH  = 4;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Line counter width and its saturation value.
    localparam int LINE_W = 24;
    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    // Token kinds.
    localparam logic [3:0] K_WCH    = 4'd0;
    localparam logic [3:0] K_WEND   = 4'd1;
    localparam logic [3:0] K_PCH    = 4'd2;
    localparam logic [3:0] K_PEND   = 4'd3;
    localparam logic [3:0] K_SCH    = 4'd4;
    localparam logic [3:0] K_SEND   = 4'd5;
    localparam logic [3:0] K_INT    = 4'd6;
    localparam logic [3:0] K_ASSIGN = 4'd7;
    localparam logic [3:0] K_BOPEN  = 4'd8;
    localparam logic [3:0] K_BCLOSE = 4'd9;
    localparam logic [3:0] K_POPEN  = 4'd10;
    localparam logic [3:0] K_PCLOSE = 4'd11;
    localparam logic [3:0] K_COMMA  = 4'd12;
    localparam logic [3:0] K_ERR    = 4'd13;

    // Error codes.
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_UNTERM   = 3'd1;
    localparam logic [2:0] E_OVERFLOW = 3'd2;
    localparam logic [2:0] E_LONESIGN = 3'd3;
    localparam logic [2:0] E_BADCHAR  = 3'd4;

    // Characters the lexer looks for.
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_0      = 8'd48;
    localparam logic [7:0] CH_9      = 8'd57;
    localparam logic [7:0] CH_EQ     = 8'd61;
    localparam logic [7:0] CH_UA     = 8'd65;
    localparam logic [7:0] CH_UZ     = 8'd90;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_UNDER  = 8'd95;
    localparam logic [7:0] CH_LA     = 8'd97;
    localparam logic [7:0] CH_LN     = 8'd110;
    localparam logic [7:0] CH_LT     = 8'd116;
    localparam logic [7:0] CH_LZ     = 8'd122;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    // Lexer modes, one-hot.
    typedef enum logic [11:0] {
        M_IDLE    = 12'b0000_0000_0001,
        M_SLASH   = 12'b0000_0000_0010,
        M_COMMENT = 12'b0000_0000_0100,
        M_WORD    = 12'b0000_0000_1000,
        M_PATH    = 12'b0000_0001_0000,
        M_SIGN    = 12'b0000_0010_0000,
        M_INT     = 12'b0000_0100_0000,
        M_INTBAD  = 12'b0000_1000_0000,
        M_STR     = 12'b0001_0000_0000,
        M_ESC     = 12'b0010_0000_0000,
        M_CONT    = 12'b0100_0000_0000,
        M_TRIM    = 12'b1000_0000_0000
    } mode_t;

    // One result word.
    typedef struct packed {
        logic [3:0]        kind;
        logic [7:0]        text;
        logic signed [31:0] value;
        logic [LINE_W-1:0] line;
        logic [2:0]        err;
        logic              last;
    } result_t;

    // Everything one source byte produces for the result queue.
    typedef struct packed {
        logic [1:0]                count;
        result_t [MAX_RES-1:0]     res;
    } step_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return ((b >= CH_UA) && (b <= CH_UZ)) || ((b >= CH_LA) && (b <= CH_LZ))
            || (b == CH_UNDER);
    endfunction

    function automatic logic is_path(input logic [7:0] b);
        return is_word(b) || (b == CH_SLASH);
    endfunction

endpackage

/* sv/sst_lexer.sv */
// ============================================================================
// sst_lexer: lexer state and single-byte step logic
// Holds the lexer mode, integer accumulator, sign and line counter, and
// works out the up to three results of each accepted byte combinationally.
// ============================================================================
module sst_lexer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     src_byte,
    input  logic           end_of_source,
    output sst_pkg::step_t step
);
    import sst_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [31:0]       acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [LINE_W-1:0] line_reg, line_next;

    logic              line_inc;
    logic              do_idle;
    logic              do_str;
    logic [1:0]        n;
    result_t [MAX_RES-1:0] res;
    logic [7:0]        b;
    logic [35:0]       acc_x10;
    logic [35:0]       acc_sum;
    logic [35:0]       acc_limit;
    logic [31:0]       int_out;

    assign b = src_byte;

    // Build a result word at the current line.
    function automatic result_t mk(input logic [3:0] kind, input logic [7:0] text,
                                   input logic [31:0] value, input logic [2:0] err,
                                   input logic [LINE_W-1:0] line);
        result_t r;
        r.kind  = kind;
        r.text  = text;
        r.value = value;
        r.line  = line;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

    // Next accumulator value on a digit, and the signed value of an integer.
    always_comb
    begin
        acc_x10   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1);
        acc_sum   = acc_x10 + {32'b0, 4'(b - CH_0)};
        acc_limit = neg_reg ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
        int_out   = neg_reg ? (32'd0 - acc_reg) : acc_reg;
    end

    // Step logic: the current mode first, then the idle or string handling
    // of the same byte where the mode hands it on.
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        line_inc  = 1'b0;
        do_idle   = 1'b0;
        do_str    = 1'b0;
        n         = 2'd0;
        res       = '0;

        if (end_of_source)
        begin
            unique case (mode_reg)
                M_SLASH:
                begin
                    res[n] = mk(K_PCH, CH_SLASH, 32'd0, E_NONE, line_reg);
                    n = n + 2'd1;
                    res[n] = mk(K_PEND, 8'd0, 32'd0, E_NONE, line_reg);
                    n = n + 2'd1;
                end
                M_WORD:
                begin
                    res[n] = mk(K_WEND, 8'd0, 32'd0, E_NONE, line_reg);
                    n = n + 2'd1;
                end
                M_PATH:
                begin
                    res[n] = mk(K_PEND, 8'd0, 32'd0, E_NONE, line_reg);
                    n = n + 2'd1;
                end
                M_SIGN:
                begin
                    res[n] = mk(K_ERR, 8'd0, 32'd0, E_LONESIGN, line_reg);
                    n = n + 2'd1;
                end
                M_INT:
                begin
                    res[n] = mk(K_INT, 8'd0, int_out, E_NONE, line_reg);
                    n = n + 2'd1;
                end
                M_STR, M_ESC, M_CONT, M_TRIM:
                begin
                    res[n] = mk(K_ERR, 8'd0, 32'd0, E_UNTERM, line_reg);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            acc_next  = 32'd0;
            neg_next  = 1'b0;
            mode_next = M_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                M_SLASH:
                begin
                    if (b == CH_SLASH)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        res[n] = mk(K_PCH, CH_SLASH, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                        if (is_path(b))
                        begin
                            res[n] = mk(K_PCH, b, 32'd0, E_NONE, line_reg);
                            n = n + 2'd1;
                            mode_next = M_PATH;
                        end
                        else
                        begin
                            res[n] = mk(K_PEND, 8'd0, 32'd0, E_NONE, line_reg);
                            n = n + 2'd1;
                            do_idle = 1'b1;
                        end
                    end
                end
                M_COMMENT:
                begin
                    if (b == CH_NL)
                    begin
                        line_inc  = 1'b1;
                        mode_next = M_IDLE;
                    end
                end
                M_WORD:
                begin
                    if (is_word(b))
                    begin
                        res[n] = mk(K_WCH, b, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        res[n] = mk(K_WEND, 8'd0, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_PATH:
                begin
                    if (is_path(b))
                    begin
                        res[n] = mk(K_PCH, b, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        res[n] = mk(K_PEND, 8'd0, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_SIGN:
                begin
                    // A single digit can never pass the limit.
                    if (is_digit(b))
                    begin
                        acc_next  = {28'd0, 4'(b - CH_0)};
                        mode_next = M_INT;
                    end
                    else
                    begin
                        res[n] = mk(K_ERR, 8'd0, 32'd0, E_LONESIGN, line_reg);
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (is_digit(b))
                    begin
                        if (acc_sum > acc_limit)
                        begin
                            res[n] = mk(K_ERR, 8'd0, 32'd0, E_OVERFLOW, line_reg);
                            n = n + 2'd1;
                            acc_next  = 32'd0;
                            neg_next  = 1'b0;
                            mode_next = M_INTBAD;
                        end
                        else
                        begin
                            acc_next = acc_sum[31:0];
                        end
                    end
                    else
                    begin
                        res[n] = mk(K_INT, 8'd0, int_out, E_NONE, line_reg);
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_INTBAD:
                begin
                    if (!is_digit(b))
                    begin
                        do_idle = 1'b1;
                    end
                end
                M_STR:
                begin
                    do_str = 1'b1;
                end
                M_ESC:
                begin
                    mode_next = M_STR;
                    if (b == CH_QUOTE)
                    begin
                        res[n] = mk(K_SCH, CH_QUOTE, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    else if (b == CH_LN)
                    begin
                        res[n] = mk(K_SCH, CH_NL, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    else if (b == CH_LT)
                    begin
                        res[n] = mk(K_SCH, CH_TAB, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    else if (b == CH_SPACE)
                    begin
                        mode_next = M_CONT;
                    end
                    else if (b == CH_NL)
                    begin
                        line_inc  = 1'b1;
                        mode_next = M_TRIM;
                    end
                    else
                    begin
                        res[n] = mk(K_SCH, CH_BSLASH, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                        res[n] = mk(K_SCH, b, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                end
                M_CONT:
                begin
                    if (b == CH_NL)
                    begin
                        line_inc  = 1'b1;
                        mode_next = M_TRIM;
                    end
                end
                M_TRIM:
                begin
                    if (b != CH_SPACE)
                    begin
                        do_str = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // Byte inside a string.
            if (do_str)
            begin
                mode_next = M_STR;
                if (b == CH_QUOTE)
                begin
                    res[n] = mk(K_SEND, 8'd0, 32'd0, E_NONE, line_reg);
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                end
                else if (b == CH_BSLASH)
                begin
                    mode_next = M_ESC;
                end
                else if (b == CH_NL)
                begin
                    res[n] = mk(K_ERR, 8'd0, 32'd0, E_UNTERM, line_reg);
                    n = n + 2'd1;
                    line_inc  = 1'b1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    res[n] = mk(K_SCH, b, 32'd0, E_NONE, line_reg);
                    n = n + 2'd1;
                end
            end

            // Byte seen with the lexer idle.
            if (do_idle)
            begin
                mode_next = M_IDLE;
                acc_next  = 32'd0;
                neg_next  = 1'b0;
                case (b)
                    CH_SPACE, CH_TAB:
                    begin
                    end
                    CH_NL:
                    begin
                        line_inc = 1'b1;
                    end
                    CH_SLASH:
                    begin
                        mode_next = M_SLASH;
                    end
                    CH_EQ:
                    begin
                        res[n] = mk(K_ASSIGN, 8'd0, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    CH_LBRACE:
                    begin
                        res[n] = mk(K_BOPEN, 8'd0, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    CH_RBRACE:
                    begin
                        res[n] = mk(K_BCLOSE, 8'd0, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    CH_LPAREN:
                    begin
                        res[n] = mk(K_POPEN, 8'd0, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    CH_RPAREN:
                    begin
                        res[n] = mk(K_PCLOSE, 8'd0, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    CH_COMMA:
                    begin
                        res[n] = mk(K_COMMA, 8'd0, 32'd0, E_NONE, line_reg);
                        n = n + 2'd1;
                    end
                    CH_QUOTE:
                    begin
                        mode_next = M_STR;
                    end
                    CH_PLUS, CH_MINUS:
                    begin
                        neg_next  = (b == CH_MINUS);
                        mode_next = M_SIGN;
                    end
                    default:
                    begin
                        if (is_digit(b))
                        begin
                            acc_next  = {28'd0, 4'(b - CH_0)};
                            mode_next = M_INT;
                        end
                        else if (is_word(b))
                        begin
                            res[n] = mk(K_WCH, b, 32'd0, E_NONE, line_reg);
                            n = n + 2'd1;
                            mode_next = M_WORD;
                        end
                        else
                        begin
                            res[n] = mk(K_ERR, 8'd0, 32'd0, E_BADCHAR, line_reg);
                            n = n + 2'd1;
                        end
                    end
                endcase
            end
        end

        // Mark the final result of this byte.
        if (n != 2'd0)
        begin
            res[n - 2'd1].last = 1'b1;
        end
    end

    // Saturating line counter.
    assign line_next = (line_inc && (line_reg != LINE_MAX)) ? line_reg + 1'b1 : line_reg;

    assign step.count = n;
    assign step.res   = res;

    // Lexer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            acc_reg  <= 32'd0;
            neg_reg  <= 1'b0;
            line_reg <= {{(LINE_W-1){1'b0}}, 1'b1};
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            line_reg <= line_next;
        end
    end

    // The accumulator only holds a value while an integer is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != M_INT && mode_reg != M_SIGN) |-> (acc_reg == 32'd0))
        else $error("accumulator not clear outside an integer");

    // The line counter starts at one and never wraps to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter at zero");

    // The line counter never goes backward.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (line_reg >= $past(line_reg)))
        else $error("line counter went backward");

endmodule

/* sv/sst_result_queue.sv */
// ============================================================================
// sst_result_queue: result buffer between the lexer and the output port
// A four-entry shift queue. It takes all results of one byte at once and hands
// them from its head register, one word per cycle while out_ready is high.
// ============================================================================
module sst_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sst_pkg::step_t   step,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output sst_pkg::result_t head
);
    import sst_pkg::*;

    result_t            slot_reg [QDEPTH];
    result_t            slot_next [QDEPTH];
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QCNT_W-1:0]  base;
    logic [QCNT_W-1:0]  push_n;
    logic [QCNT_W-1:0]  rel;
    logic               pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign head      = slot_reg[0];

    // Room for a full byte's worth of results even if the head word stays.
    assign in_ready  = (count_reg <= QCNT_W'(1));

    assign push_n = push ? QCNT_W'(step.count) : '0;
    assign base   = count_reg - QCNT_W'(pop);

    // Shift down on a pop, then drop the new results in behind.
    always_comb
    begin
        count_next = base + push_n;
        rel        = '0;
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && (i < QDEPTH - 1))
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            else
            begin
                slot_next[i] = slot_reg[i];
            end
            rel = QCNT_W'(i) - base;
            if ((QCNT_W'(i) >= base) && (rel < push_n))
            begin
                slot_next[i] = step.res[rel[1:0]];
            end
        end
    end

    // Result words need no reset; the count does.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    // Results only arrive while the queue has room for a whole byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && step.count != 2'd0) |-> in_ready)
        else $error("results pushed while the queue was full");

    // A word leaving with nothing arriving shortens the queue by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_n == '0) |=> (count_reg == $past(count_reg) - QCNT_W'(1)))
        else $error("result queue count out of step");

endmodule

/* sv/script_source_tokenizer_top.sv */
// ============================================================================
// script_source_tokenizer_top: streaming tokenizer for script source text
// Takes one source byte per word and sends out token results.
// ============================================================================
// The block accepts one source byte per cycle while the input is ready and
// works it out in the same cycle it is taken, so bytes with at most one
// result each stream at one word per cycle while the output is ready. Up to
// three results of one byte go out in turn; results wait in a four-entry
// queue, and the input is ready whenever at most one result is still waiting.
// A byte that yields no result (space, comment text, digits of an integer)
// puts nothing on the output. Set the end-of-source flag in s_tuser on a word
// of its own to close any open token. The block needs no clearing after reset.
module script_source_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] text_byte, [39:8] int_value,
                                   // [63:40] line_number, [66:64] error_code,
                                   // [71:67] zero
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // last_of_run
);
    import sst_pkg::*;

    logic    accept;
    step_t   step;
    result_t head;

    assign accept = s_tvalid && s_tready;

    // Lexer state and per-byte step.
    sst_lexer u_lexer (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .src_byte      (s_tdata),
        .end_of_source (s_tuser[0]),
        .step          (step)
    );

    // Result buffer feeding the output port.
    sst_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .step      (step),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    // Output word packing.
    assign m_tdata = {5'd0, head.err, head.line, head.value, head.text};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

/* test/sst_checker.sv */
// ============================================================================
// sst_checker: token prediction and comparison for the script tokenizer
// Watches both stream channels, runs its own lexer on every accepted source
// word and checks each result word against the oldest predicted token.
// ============================================================================
module sst_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_source
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [7:0] text_byte, [39:8] int_value,
                                   // [63:40] line_number, [66:64] error_code
    input  logic [3:0]  m_tuser,   // [3:0] token_kind
    input  logic        m_tlast,   // last_of_run
    output int          fail_count,
    output int          pending
);
    import sst_pkg::*;

    typedef struct {
        logic [3:0]        kind;
        logic [7:0]        text;
        logic [31:0]       value;
        logic [LINE_W-1:0] line;
        logic [2:0]        err;
        logic              last;
    } token_t;

    // Tokens predicted but not yet seen, and those of the current word.
    token_t tokens_due[$];
    token_t step_tokens[$];

    // Lexer state of the prediction.
    mode_t             lex_mode;
    logic [31:0]       int_mag;
    logic              int_neg;
    logic [LINE_W-1:0] line_no;
    int                result_index;

    function automatic logic dec_char(input logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic logic word_char(input logic [7:0] b);
        return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) || b == CH_UNDER;
    endfunction

    function automatic logic path_char(input logic [7:0] b);
        return word_char(b) || b == CH_SLASH;
    endfunction

    task automatic add_token(input logic [3:0] kind, input logic [7:0] text,
                             input logic [31:0] value, input logic [2:0] err);
        token_t t;
        if (step_tokens.size() < MAX_RES)
        begin
            t.kind  = kind;
            t.text  = text;
            t.value = value;
            t.line  = line_no;
            t.err   = err;
            t.last  = 1'b0;
            step_tokens.insert(step_tokens.size(), t);
        end
    endtask

    task automatic bump_line();
        if (line_no != LINE_MAX)
            line_no = line_no + 1'b1;
    endtask

    task automatic drop_int();
        int_mag = '0;
        int_neg = 1'b0;
    endtask

    task automatic push_int();
        add_token(K_INT, 8'd0, int_neg ? (32'd0 - int_mag) : int_mag, E_NONE);
        drop_int();
    endtask

    // A byte seen with no token open.
    task automatic lex_idle(input logic [7:0] b);
        lex_mode = M_IDLE;
        case (b)
            CH_SPACE, CH_TAB: ;
            CH_NL:     bump_line();
            CH_SLASH:  lex_mode = M_SLASH;
            CH_EQ:     add_token(K_ASSIGN, 8'd0, 32'd0, E_NONE);
            CH_LBRACE: add_token(K_BOPEN, 8'd0, 32'd0, E_NONE);
            CH_RBRACE: add_token(K_BCLOSE, 8'd0, 32'd0, E_NONE);
            CH_LPAREN: add_token(K_POPEN, 8'd0, 32'd0, E_NONE);
            CH_RPAREN: add_token(K_PCLOSE, 8'd0, 32'd0, E_NONE);
            CH_COMMA:  add_token(K_COMMA, 8'd0, 32'd0, E_NONE);
            CH_QUOTE:  lex_mode = M_STR;
            CH_PLUS, CH_MINUS:
            begin
                drop_int();
                int_neg  = (b == CH_MINUS);
                lex_mode = M_SIGN;
            end
            default:
            begin
                if (dec_char(b))
                begin
                    drop_int();
                    int_mag  = 32'(b - CH_0);
                    lex_mode = M_INT;
                end
                else if (word_char(b))
                begin
                    add_token(K_WCH, b, 32'd0, E_NONE);
                    lex_mode = M_WORD;
                end
                else
                    add_token(K_ERR, 8'd0, 32'd0, E_BADCHAR);
            end
        endcase
    endtask

    // Append a digit; a negative number may reach one more than a positive one.
    task automatic lex_digit(input logic [7:0] b);
        logic [63:0] bound;
        logic [63:0] grown;
        bound = int_neg ? 64'd2147483648 : 64'd2147483647;
        grown = 64'(int_mag) * 64'd10 + 64'(b - CH_0);
        if (grown > bound)
        begin
            add_token(K_ERR, 8'd0, 32'd0, E_OVERFLOW);
            drop_int();
            lex_mode = M_INTBAD;
        end
        else
        begin
            int_mag  = grown[31:0];
            lex_mode = M_INT;
        end
    endtask

    // A plain byte inside a quoted string.
    task automatic lex_string(input logic [7:0] b);
        lex_mode = M_STR;
        if (b == CH_QUOTE)
        begin
            add_token(K_SEND, 8'd0, 32'd0, E_NONE);
            lex_mode = M_IDLE;
        end
        else if (b == CH_BSLASH)
            lex_mode = M_ESC;
        else if (b == CH_NL)
        begin
            add_token(K_ERR, 8'd0, 32'd0, E_UNTERM);
            bump_line();
            lex_mode = M_IDLE;
        end
        else
            add_token(K_SCH, b, 32'd0, E_NONE);
    endtask

    // End of source closes whatever token is open.
    task automatic lex_close();
        case (lex_mode)
            M_SLASH:
            begin
                add_token(K_PCH, CH_SLASH, 32'd0, E_NONE);
                add_token(K_PEND, 8'd0, 32'd0, E_NONE);
            end
            M_WORD: add_token(K_WEND, 8'd0, 32'd0, E_NONE);
            M_PATH: add_token(K_PEND, 8'd0, 32'd0, E_NONE);
            M_SIGN: add_token(K_ERR, 8'd0, 32'd0, E_LONESIGN);
            M_INT:  push_int();
            M_STR, M_ESC, M_CONT, M_TRIM: add_token(K_ERR, 8'd0, 32'd0, E_UNTERM);
            default: ;
        endcase
        drop_int();
        lex_mode = M_IDLE;
    endtask

    // Predict the tokens of one accepted source word.
    task automatic lex_step(input logic [7:0] b, input logic eos);
        step_tokens.delete();
        if (eos)
            lex_close();
        else
        begin
            case (lex_mode)
                M_SLASH:
                begin
                    if (b == CH_SLASH)
                        lex_mode = M_COMMENT;
                    else
                    begin
                        add_token(K_PCH, CH_SLASH, 32'd0, E_NONE);
                        if (path_char(b))
                        begin
                            add_token(K_PCH, b, 32'd0, E_NONE);
                            lex_mode = M_PATH;
                        end
                        else
                        begin
                            add_token(K_PEND, 8'd0, 32'd0, E_NONE);
                            lex_idle(b);
                        end
                    end
                end
                M_COMMENT:
                begin
                    if (b == CH_NL)
                    begin
                        bump_line();
                        lex_mode = M_IDLE;
                    end
                end
                M_WORD:
                begin
                    if (word_char(b))
                        add_token(K_WCH, b, 32'd0, E_NONE);
                    else
                    begin
                        add_token(K_WEND, 8'd0, 32'd0, E_NONE);
                        lex_idle(b);
                    end
                end
                M_PATH:
                begin
                    if (path_char(b))
                        add_token(K_PCH, b, 32'd0, E_NONE);
                    else
                    begin
                        add_token(K_PEND, 8'd0, 32'd0, E_NONE);
                        lex_idle(b);
                    end
                end
                M_SIGN:
                begin
                    if (dec_char(b))
                    begin
                        int_mag = '0;
                        lex_digit(b);
                    end
                    else
                    begin
                        add_token(K_ERR, 8'd0, 32'd0, E_LONESIGN);
                        drop_int();
                        lex_idle(b);
                    end
                end
                M_INT:
                begin
                    if (dec_char(b))
                        lex_digit(b);
                    else
                    begin
                        push_int();
                        lex_idle(b);
                    end
                end
                M_INTBAD:
                begin
                    if (!dec_char(b))
                    begin
                        drop_int();
                        lex_idle(b);
                    end
                end
                M_STR: lex_string(b);
                M_ESC:
                begin
                    lex_mode = M_STR;
                    if (b == CH_QUOTE)
                        add_token(K_SCH, CH_QUOTE, 32'd0, E_NONE);
                    else if (b == CH_LN)
                        add_token(K_SCH, CH_NL, 32'd0, E_NONE);
                    else if (b == CH_LT)
                        add_token(K_SCH, CH_TAB, 32'd0, E_NONE);
                    else if (b == CH_SPACE)
                        lex_mode = M_CONT;
                    else if (b == CH_NL)
                    begin
                        bump_line();
                        lex_mode = M_TRIM;
                    end
                    else
                    begin
                        add_token(K_SCH, CH_BSLASH, 32'd0, E_NONE);
                        add_token(K_SCH, b, 32'd0, E_NONE);
                    end
                end
                M_CONT:
                begin
                    if (b == CH_NL)
                    begin
                        bump_line();
                        lex_mode = M_TRIM;
                    end
                end
                M_TRIM:
                begin
                    if (b != CH_SPACE)
                        lex_string(b);
                end
                default: lex_idle(b);
            endcase
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            tokens_due.insert(tokens_due.size(), step_tokens[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                 result_index, what, got, want);
        fail_count++;
    endtask

    // Source words are predicted before result words are checked, so a
    // result of the same edge still finds its token waiting.
    always @(posedge clk or negedge rst_n)
    begin
        token_t t;
        if (!rst_n)
        begin
            lex_mode     = M_IDLE;
            int_mag      = '0;
            int_neg      = 1'b0;
            line_no      = {{(LINE_W-1){1'b0}}, 1'b1};
            result_index = 0;
            fail_count   = 0;
            tokens_due.delete();
            pending     <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                lex_step(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
            begin
                if (tokens_due.size() == 0)
                    report_mismatch("unexpected result, token_kind", 32'(m_tuser), 32'd0);
                else
                begin
                    t = tokens_due.pop_front();
                    if (m_tuser !== t.kind)
                        report_mismatch("token_kind", 32'(m_tuser), 32'(t.kind));
                    if (m_tdata[7:0] !== t.text)
                        report_mismatch("text_byte", 32'(m_tdata[7:0]), 32'(t.text));
                    if (m_tdata[39:8] !== t.value)
                        report_mismatch("int_value", m_tdata[39:8], t.value);
                    if (m_tdata[63:40] !== t.line)
                        report_mismatch("line_number", 32'(m_tdata[63:40]), 32'(t.line));
                    if (m_tdata[66:64] !== t.err)
                        report_mismatch("error_code", 32'(m_tdata[66:64]), 32'(t.err));
                    if (m_tlast !== t.last)
                        report_mismatch("last_of_run", 32'(m_tlast), 32'(t.last));
                end
                result_index++;
            end
            pending <= tokens_due.size();
        end
    end

endmodule

/* test/tb.sv */
// ============================================================================
// tb: stream test of the script source tokenizer
// Feeds a short directed source text and then random script fragments (words,
// paths, integers near the limits, strings with escapes, comments, noise and
// end-of-source words) with random gaps and output stalls; a checker beside
// the block predicts and compares every result word.
// ============================================================================
module tb;
    import sst_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 450;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [7:0] b;
        logic       eos;
    } src_word_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;

    src_word_t   src_q[$];
    int          random_count = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    always #6 clk = ~clk;

    script_source_tokenizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sst_checker token_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Idle lengths: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Receiver stalls.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 20)
        begin
            stall_left = pick_gap();
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: too many cycles in a row with no word moving on either side.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // Append one source word to the send queue.
    task automatic queue_word(input logic [7:0] b, input logic eos);
        src_word_t w;
        w.b   = b;
        w.eos = eos;
        src_q.insert(src_q.size(), w);
    endtask

    task automatic put_byte(input logic [7:0] b);
        queue_word(b, 1'b0);
        random_count++;
    endtask

    // Comment text is skipped by the block and does not count.
    task automatic put_quiet(input logic [7:0] b);
        queue_word(b, 1'b0);
    endtask

    task automatic put_eos();
        queue_word(8'($urandom_range(0, 255)), 1'b1);
        random_count++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic logic [7:0] word_byte();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'(CH_UA + r);
        if (r < 52)
            return 8'(CH_LA + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] digit_byte();
        return 8'(CH_0 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] single_byte();
        case ($urandom_range(0, 5))
            0: return CH_EQ;
            1: return CH_LBRACE;
            2: return CH_RBRACE;
            3: return CH_LPAREN;
            4: return CH_RPAREN;
            default: return CH_COMMA;
        endcase
    endfunction

    // Any byte that does not end or escape a string; mostly printable.
    function automatic logic [7:0] text_char();
        logic [7:0] b;
        do
        begin
            if ($urandom_range(0, 3) == 0)
                b = 8'($urandom_range(0, 255));
            else
                b = 8'($urandom_range(32, 126));
        end
        while (b == CH_QUOTE || b == CH_BSLASH || b == CH_NL);
        return b;
    endfunction

    // A byte that cannot start any token.
    function automatic logic [7:0] bad_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= CH_0 && b <= CH_9) || (b >= CH_UA && b <= CH_UZ)
               || (b >= CH_LA && b <= CH_LZ) || b == CH_UNDER || b == CH_SPACE
               || b == CH_TAB || b == CH_NL || b == CH_SLASH || b == CH_EQ
               || b == CH_LBRACE || b == CH_RBRACE || b == CH_LPAREN
               || b == CH_RPAREN || b == CH_COMMA || b == CH_QUOTE
               || b == CH_PLUS || b == CH_MINUS);
        return b;
    endfunction

    task automatic put_number();
        int r;
        int n;
        r = $urandom_range(0, 2);
        if (r == 1)
            put_byte(CH_PLUS);
        else if (r == 2)
            put_byte(CH_MINUS);
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            n = $urandom_range(1, 4);
            repeat (n) put_byte(digit_byte());
        end
        else if (r == 6)
            put_text("2147483647");
        else if (r == 7)
            put_text("2147483648");
        else if (r == 8)
        begin
            n = $urandom_range(10, 12);
            repeat (n) put_byte(digit_byte());
        end
        else
            put_text("-2147483648");
    endtask

    task automatic put_string();
        int r;
        int n;
        put_byte(CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                put_byte(text_char());
            else if (r < 65)
                put_text("\\\"");
            else if (r < 70)
                put_text("\\n");
            else if (r < 75)
                put_text("\\t");
            else if (r < 83)
            begin
                put_byte(CH_BSLASH);
                put_byte(text_char());
            end
            else if (r < 91)
            begin
                put_text("\\ ");
                repeat ($urandom_range(0, 2)) put_byte(text_char());
                put_byte(CH_NL);
                repeat ($urandom_range(0, 3)) put_byte(CH_SPACE);
            end
            else
            begin
                put_byte(CH_BSLASH);
                put_byte(CH_NL);
                repeat ($urandom_range(0, 3)) put_byte(CH_SPACE);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 88)
            put_byte(CH_QUOTE);
        else if (r < 94)
            put_byte(CH_NL);
        else
            put_eos();
    endtask

    // One random piece of script text, usually followed by a separator.
    task automatic put_fragment();
        int r;
        case ($urandom_range(0, 13))
            0, 1: repeat ($urandom_range(1, 6)) put_byte(word_byte());
            2:
            begin
                put_byte(CH_SLASH);
                repeat ($urandom_range(0, 5))
                    put_byte(($urandom_range(0, 4) == 0) ? CH_SLASH : word_byte());
            end
            3, 4: put_number();
            5, 6: put_string();
            7: put_byte(single_byte());
            8: put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            9:
            begin
                put_text("//");
                repeat ($urandom_range(0, 8)) put_quiet(text_char());
                if ($urandom_range(0, 5) == 0)
                    put_eos();
                else
                    put_byte(CH_NL);
            end
            10:
            begin
                put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                if ($urandom_range(0, 3) == 0)
                    put_eos();
                else
                    put_byte($urandom_range(0, 1) ? word_byte() : single_byte());
            end
            11: put_byte(bad_byte());
            12: repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
            default: put_eos();
        endcase
        r = $urandom_range(0, 99);
        if (r < 60 && r >= 30)
            put_byte(CH_SPACE);
        else if (r < 75 && r >= 60)
            put_byte(CH_NL);
        else if (r < 85 && r >= 75)
            put_byte(CH_TAB);
        else if (r >= 85)
            put_byte(single_byte());
    endtask

    // Offer one source word, after a random gap, and wait until it is taken.
    task automatic send_word(input src_word_t w);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w.b;
        s_tuser  <= w.eos;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_all();
        while (src_q.size() > 0)
            send_word(src_q.pop_front());
    endtask

    // Hold the sender until every predicted token has come out.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    initial
    begin : stimulus
        int next_pause;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: every single-character token, word, integers, lone sign,
        // the byte extremes as bad characters, a comment, a path closed by
        // end of source, an unknown escape and a held slash at the end.
        put_text("x={(1,-2)}");
        put_text("+ ");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("//\n");
        put_text("/a");
        put_eos();
        put_text("\"\\q\"");
        put_byte(CH_SLASH);
        put_eos();
        send_all();
        drain();

        // Random script text, with calm stretches and periodic full drains.
        random_count = 0;
        next_pause   = 120;
        while (random_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            put_fragment();
            send_all();
            if (random_count >= next_pause)
            begin
                drain();
                next_pause += 120;
            end
        end
        put_eos();
        send_all();
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
